// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the fuzzy subsequence scorer.
// Each macro checks a property on the rising clock edge outside of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// The expression must never be true at a clock edge while reset is released.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

// ===== hdl/fss_pkg.sv =====
// Package of the fuzzy subsequence scorer: widths, character codes,
// register indexes and the lowercase helper. No dependencies.
package fss_pkg;

    localparam int MAX_QUERY   = 16;
    localparam int QPOS_W      = 5;
    localparam int QIDX_W      = 4;
    localparam int SCORE_W     = 12;
    localparam int OUT_W       = 11;
    localparam int RUN_W       = 4;
    localparam int GAIN_W      = 7;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [QPOS_W-1:0] QUERY_LIMIT = QPOS_W'(MAX_QUERY);

    localparam logic [GAIN_W-1:0] MATCH_GAIN    = 7'd10;
    localparam logic [GAIN_W-1:0] BOUNDARY_GAIN = 7'd20;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = -12'sd2048;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 12'sd2047;
    localparam logic [OUT_W-1:0]          SCORE_CAP = 11'd1080;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_DASH       = 8'h2D;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUERY_LENGTH = 2'd0,
        REG_QUERY_LOW    = 2'd1,
        REG_QUERY_HIGH   = 2'd2
    } cfg_reg_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== hdl/fuzzy_subsequence_scorer.sv =====
// The score is written to the result register when the last target character leaves the input register.
// Throughput: one target character per cycle; only the single result register can stall it.
// The match state is updated by combinational logic behind the input register.
// Reset (rst_n low, asynchronous) clears the query registers and all match state.
// Depends on fss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fuzzy_subsequence_scorer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           target_valid,
    output logic                           target_ready,
    input  logic [7:0]                     target_char,
    input  logic                           char_present,
    input  logic                           last_char,
    output logic                           score_valid,
    input  logic                           score_ready,
    output logic [fss_pkg::OUT_W-1:0]      match_score
);

    logic [fss_pkg::QPOS_W-1:0]     query_length_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] query_low_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] query_high_reg;

    logic       pipe_valid_reg;
    logic [7:0] pipe_char_reg;
    logic       pipe_present_reg;
    logic       pipe_last_reg;

    logic [fss_pkg::QPOS_W-1:0]         query_position_reg, query_position_next;
    logic signed [fss_pkg::SCORE_W-1:0] running_score_reg, running_score_next;
    logic [fss_pkg::RUN_W-1:0]          match_run_reg, match_run_next;
    logic [7:0]                         previous_char_reg, previous_char_next;
    logic                               at_target_start_reg, at_target_start_next;
    logic                               saw_any_char_reg, saw_any_char_next;

    logic                       score_valid_reg;
    logic [fss_pkg::OUT_W-1:0]  match_score_reg, match_score_next;

    logic                                advance;
    logic [fss_pkg::QPOS_W-1:0]          qlen;
    logic [2*fss_pkg::CFG_DATA_W-1:0]    query_all;
    logic [7:0]                          query_char;
    logic [7:0]                          tc;
    logic                                boundary;
    logic [fss_pkg::GAIN_W-1:0]          gain;
    logic signed [fss_pkg::SCORE_W:0]    delta;
    logic signed [fss_pkg::SCORE_W:0]    score_sum;
    logic signed [fss_pkg::SCORE_W-1:0]  score_sat;
    logic                                found;

    assign advance = pipe_valid_reg && (!pipe_last_reg || !score_valid_reg || score_ready);
    assign target_ready = !pipe_valid_reg || advance;
    assign score_valid = score_valid_reg;
    assign match_score = match_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
            query_low_reg    <= '0;
            query_high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fss_pkg::REG_QUERY_LENGTH: query_length_reg <= cfg_data[fss_pkg::QPOS_W-1:0];
                fss_pkg::REG_QUERY_LOW:    query_low_reg    <= cfg_data;
                fss_pkg::REG_QUERY_HIGH:   query_high_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else if (target_ready)
        begin
            pipe_valid_reg <= target_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (target_ready && target_valid)
        begin
            pipe_char_reg    <= target_char;
            pipe_present_reg <= char_present;
            pipe_last_reg    <= last_char;
        end
    end

    assign qlen = (query_length_reg > fss_pkg::QUERY_LIMIT) ? fss_pkg::QUERY_LIMIT
                                                            : query_length_reg;
    assign query_all  = {query_high_reg, query_low_reg};
    assign query_char = fss_pkg::to_lower(
        query_all[{query_position_reg[fss_pkg::QIDX_W-1:0], 3'b000} +: 8]);
    assign tc = fss_pkg::to_lower(pipe_char_reg);

    assign boundary = at_target_start_reg
                      || previous_char_reg == fss_pkg::CHAR_UNDERSCORE
                      || previous_char_reg == fss_pkg::CHAR_SPACE
                      || previous_char_reg == fss_pkg::CHAR_DASH;
    assign gain = fss_pkg::MATCH_GAIN
                  + {1'b0, match_run_reg, 2'b00}
                  + {3'b000, match_run_reg}
                  + (boundary ? fss_pkg::BOUNDARY_GAIN : '0);

    always_comb
    begin
        delta = '0;
        if (pipe_present_reg)
        begin
            if (query_position_reg >= qlen)
            begin
                delta = -13'sd1;
            end
            else if (query_char == tc)
            begin
                delta = $signed({{(fss_pkg::SCORE_W+1-fss_pkg::GAIN_W){1'b0}}, gain});
            end
        end
    end

    assign score_sum = {running_score_reg[fss_pkg::SCORE_W-1], running_score_reg} + delta;

    always_comb
    begin
        if (score_sum < $signed({fss_pkg::SCORE_MIN[fss_pkg::SCORE_W-1], fss_pkg::SCORE_MIN}))
        begin
            score_sat = fss_pkg::SCORE_MIN;
        end
        else if (score_sum > $signed({1'b0, fss_pkg::SCORE_MAX}))
        begin
            score_sat = fss_pkg::SCORE_MAX;
        end
        else
        begin
            score_sat = score_sum[fss_pkg::SCORE_W-1:0];
        end
    end

    always_comb
    begin
        query_position_next  = query_position_reg;
        running_score_next   = running_score_reg;
        match_run_next       = match_run_reg;
        previous_char_next   = previous_char_reg;
        at_target_start_next = at_target_start_reg;
        saw_any_char_next    = saw_any_char_reg;
        if (pipe_present_reg)
        begin
            if (query_position_reg >= qlen)
            begin
                running_score_next = score_sat;
            end
            else if (query_char == tc)
            begin
                running_score_next  = score_sat;
                query_position_next = query_position_reg + 1'b1;
                if (match_run_reg != '1)
                begin
                    match_run_next = match_run_reg + 1'b1;
                end
            end
            else
            begin
                match_run_next = '0;
            end
            previous_char_next   = tc;
            at_target_start_next = 1'b0;
            saw_any_char_next    = 1'b1;
        end
    end

    assign found = (qlen != '0) && saw_any_char_next && (query_position_next >= qlen);

    always_comb
    begin
        match_score_next = '0;
        if (found)
        begin
            if (running_score_next > 0)
            begin
                match_score_next = running_score_next[fss_pkg::OUT_W-1:0];
            end
            else
            begin
                match_score_next = fss_pkg::OUT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_position_reg  <= '0;
            running_score_reg   <= '0;
            match_run_reg       <= '0;
            previous_char_reg   <= '0;
            at_target_start_reg <= 1'b1;
            saw_any_char_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (pipe_last_reg)
            begin
                query_position_reg  <= '0;
                running_score_reg   <= '0;
                match_run_reg       <= '0;
                previous_char_reg   <= '0;
                at_target_start_reg <= 1'b1;
                saw_any_char_reg    <= 1'b0;
            end
            else
            begin
                query_position_reg  <= query_position_next;
                running_score_reg   <= running_score_next;
                match_run_reg       <= match_run_next;
                previous_char_reg   <= previous_char_next;
                at_target_start_reg <= at_target_start_next;
                saw_any_char_reg    <= saw_any_char_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_valid_reg <= 1'b0;
        end
        else if (advance && pipe_last_reg)
        begin
            score_valid_reg <= 1'b1;
        end
        else if (score_ready)
        begin
            score_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pipe_last_reg)
        begin
            match_score_reg <= match_score_next;
        end
    end

    // A full query gains at most 1080 points, and penalties only lower the score.
    `ASSERT_NEVER(score_in_range, clk, rst_n, score_valid_reg && (match_score_reg > fss_pkg::SCORE_CAP), "match score above the largest reachable value")

    `ASSERT_NEVER(position_in_range, clk, rst_n, query_position_reg > fss_pkg::QUERY_LIMIT, "query position past the longest query")

    `ASSERT_CLK(clear_after_last, clk, rst_n, advance && pipe_last_reg |=> (query_position_reg == '0) && (running_score_reg == '0) && at_target_start_reg && !saw_any_char_reg, "match state not cleared after the last character")

    `ASSERT_CLK(stall_only_when_full, clk, rst_n, pipe_valid_reg && !advance |-> score_valid_reg && !score_ready, "input stage stalled while the result register could take a transfer")

endmodule
